// ===== src/iks_pkg.sv =====
// ----------------------------------------------------------------------------
// iks_pkg
// Shared types and constants for the integer key set table.
// ----------------------------------------------------------------------------
package iks_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned COUNT_W      = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // request op codes as they appear on the port
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic               was_present;
    logic               status;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    kind_e            kind;
    logic [KEY_W-1:0] key;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_WRITE = 5'b10000
  } back_state_e;

endpackage

// ===== src/iks_ram.sv =====
// ----------------------------------------------------------------------------
// iks_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module iks_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== src/iks_front.sv =====
// ----------------------------------------------------------------------------
// iks_front
// Takes requests, decodes the op into a command kind and holds commands in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module iks_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  iks_pkg::req_t     req_i,
  input  logic              clearing_i,
  input  logic              pop_i,
  output logic              busy,
  output iks_pkg::q_head_t  head_o
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PW     = $clog2(QDEPTH);

  iks_pkg::cmd_t     entry_q [QDEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PW:0]       fill_q, fill_d;
  logic              push;
  logic              pop;
  logic              full;
  iks_pkg::cmd_t     cmd_in;

  // op 3 has no meaning of its own and behaves as a lookup
  always_comb begin
    cmd_in.key = req_i.key;
    case (req_i.op)
      iks_pkg::OP_ADD:    cmd_in.kind = iks_pkg::KIND_ADD;
      iks_pkg::OP_REMOVE: cmd_in.kind = iks_pkg::KIND_REMOVE;
      default:            cmd_in.kind = iks_pkg::KIND_LOOKUP;
    endcase
  end

  assign full   = (fill_q == (PW+1)'(QDEPTH));
  assign busy   = full | clearing_i;
  assign push   = start & ~busy;
  assign pop    = pop_i & (fill_q != '0);

  assign head_o.valid = (fill_q != '0);
  assign head_o.cmd   = entry_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    case ({push, pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== src/iks_back.sv =====
// ----------------------------------------------------------------------------
// iks_back
// Executes commands: clears the slot memory after reset, scans every slot
// for the key and the lowest free slot, then writes back and reports.
// ----------------------------------------------------------------------------
module iks_back #(
  parameter int unsigned CAPACITY = iks_pkg::CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iks_pkg::q_head_t  head_i,
  output logic              pop_o,
  output logic              clearing_o,
  output logic              res_valid_o,
  output iks_pkg::rsp_t     rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = iks_pkg::KEY_W + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

  iks_pkg::back_state_e state_q, state_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                 hit_q, hit_d;
  logic [AW-1:0]        hit_idx_q, hit_idx_d;
  logic                 free_q, free_d;
  logic [AW-1:0]        free_idx_q, free_idx_d;
  iks_pkg::cmd_t        cmd_q, cmd_d;
  logic [CW-1:0]        held_q, held_d;
  logic                 res_valid_q, res_valid_d;
  iks_pkg::rsp_t        rsp_q, rsp_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [DW-1:0]        ram_wdata;
  logic [DW-1:0]        ram_rdata;
  logic                 slot_valid;
  logic                 do_add, add_full, do_rm;

  iks_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign slot_valid = ram_rdata[DW-1];

  assign do_add   = (cmd_q.kind == iks_pkg::KIND_ADD) & ~hit_q & free_q;
  assign add_full = (cmd_q.kind == iks_pkg::KIND_ADD) & ~hit_q & ~free_q;
  assign do_rm    = (cmd_q.kind == iks_pkg::KIND_REMOVE) & hit_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    cmd_d       = cmd_q;
    held_d      = held_q;
    res_valid_d = 1'b0;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_addr    = idx_q;
    ram_wdata   = '0;
    pop_o       = 1'b0;

    // compare stage, in the cycle after the read address
    if (cmp_vld_q) begin
      if (slot_valid && (ram_rdata[DW-2:0] == cmd_q.key) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      if (!slot_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end

    case (state_q)
      iks_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = iks_pkg::ST_IDLE;
        end
      end
      iks_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          cmd_d   = head_i.cmd;
          idx_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = iks_pkg::ST_SCAN;
        end
      end
      iks_pkg::ST_SCAN: begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = idx_q;
        idx_d     = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = iks_pkg::ST_DRAIN;
        end
      end
      iks_pkg::ST_DRAIN: begin
        state_d = iks_pkg::ST_WRITE;
      end
      iks_pkg::ST_WRITE: begin
        if (do_add) begin
          ram_we    = 1'b1;
          ram_addr  = free_idx_q;
          ram_wdata = {1'b1, cmd_q.key};
          held_d    = held_q + 1'b1;
        end else if (do_rm) begin
          ram_we    = 1'b1;
          ram_addr  = hit_idx_q;
          held_d    = held_q - 1'b1;
        end
        res_valid_d       = 1'b1;
        rsp_d.was_present = hit_q;
        rsp_d.status      = add_full;
        if (CW > iks_pkg::COUNT_W && held_d > CW'(iks_pkg::COUNT_MAX)) begin
          rsp_d.entry_count = iks_pkg::COUNT_MAX;
        end else begin
          rsp_d.entry_count = iks_pkg::COUNT_W'(held_d);
        end
        state_d = iks_pkg::ST_IDLE;
      end
      default: begin
        state_d = iks_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iks_pkg::ST_CLEAR;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      held_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      held_q      <= held_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    cmd_q      <= cmd_d;
    rsp_q      <= rsp_d;
  end

  assign clearing_o  = (state_q == iks_pkg::ST_CLEAR);
  assign res_valid_o = res_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== src/integer_key_set_table.sv =====
// ----------------------------------------------------------------------------
// integer_key_set_table
// Bounded set of signed 32-bit keys with add, remove and contains.
// ----------------------------------------------------------------------------
// A request (op, key) transfers on a clock edge with start high and busy
// low. Ops: 0 add, 1 remove, 2 contains (3 behaves as contains). Requests
// go into a two-entry queue; the back end takes them one at a time.
// Each request yields one result on rsp_o, shown for a single cycle with
// res_valid_o high; the receiver cannot stall, so nothing backs up there.
// Per request the back end scans all CAPACITY slots through one RAM port,
// one slot a cycle, after picking the request up from the queue; a drain
// state then finishes the compare and a write state writes back and
// raises the result strobe. The back end takes no new request from the
// queue until it is done with the current one; the queue still fills.
// After reset the slot memory is cleared, one slot a cycle; busy stays
// high during that pass.
// ----------------------------------------------------------------------------
module integer_key_set_table #(
  parameter int unsigned CAPACITY = iks_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  iks_pkg::req_t req_i,
  output logic          busy,
  output logic          res_valid_o,
  output iks_pkg::rsp_t rsp_o
);

  iks_pkg::q_head_t head;
  logic             pop;
  logic             clearing;

  iks_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .clearing_i (clearing),
    .pop_i      (pop),
    .busy       (busy),
    .head_o     (head)
  );

  iks_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== src/iks_checker.sv =====
// ----------------------------------------------------------------------------
// iks_checker
// Port-level checks for the integer key set table.
// ----------------------------------------------------------------------------
module iks_checker #(
  parameter int unsigned CAPACITY = iks_pkg::CAPACITY_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input iks_pkg::req_t req_i,
  input logic          busy,
  input logic          res_valid_o,
  input iks_pkg::rsp_t rsp_o
);

  localparam logic [iks_pkg::COUNT_W-1:0] FULL_CNT =
    (CAPACITY > 127) ? iks_pkg::COUNT_MAX : iks_pkg::COUNT_W'(CAPACITY);

  // each result needs a pickup, a full scan and a write-back, so results never come back to back
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("results on consecutive cycles");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (rsp_o.entry_count <= FULL_CNT))
    else $error("entry count above capacity");

  // a rejected add only happens on a full set with the key absent
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && rsp_o.status) |-> (!rsp_o.was_present &&
                                       rsp_o.entry_count == FULL_CNT))
    else $error("reject without a full set");

  // the first result needs the clearing pass plus one full scan
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (busy && !res_valid_o))
    else $error("block active right after reset");

endmodule

bind integer_key_set_table iks_checker #(.CAPACITY(CAPACITY)) u_iks_checker (.*);
